@@ rtl/indexed_doubly_linked_list_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the indexed doubly linked list
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define IDLL_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("indexed_doubly_linked_list: port check failed");

// next-cycle implication, sampled on clk, off while in reset
`define IDLL_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("indexed_doubly_linked_list: port check failed");

`endif

@@ rtl/idll_pkg.sv @@
// ----------------------------------------------------------------------------
// idll_pkg
// Types and fixed constants shared by the linked list controller, datapath
// and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package idll_pkg;

	localparam int OP_W     = 3;
	localparam int POS_W    = 10;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int LINK_W   = 10;
	localparam int COUNT_W  = 10;

	typedef enum logic [OP_W-1:0] {
		OP_GET    = 3'd0,
		OP_NEXT   = 3'd1,
		OP_PREV   = 3'd2,
		OP_INSERT = 3'd3,
		OP_DELETE = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_SENTINEL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LINK,
		S_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;  // beat accepted, launch table reads
		logic exec;  // read data back, first write pass
		logic link;  // second write pass
		logic emit;  // move result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_link;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/indexed_doubly_linked_list.sv @@
// Doubly linked list in a fixed table of CAPACITY slots, slot 0 being the
// circular sentinel and unused slots chained as a free list. One operation
// is in flight at a time, going through an exec and then an emit state.
// Get, next and prev, and any insert or delete that leaves the list as
// it is, go from exec straight to emit; an insert or delete that relinks
// passes a link state between them, as each link table has a single
// write port and the operation writes two next entries, so the neighbor
// links are patched in a second write pass after the registered table
// read. The next beat is accepted at the edge where the result moves into
// the output register. While a stalled result sits in the output register,
// one more operation runs up to its own result and then holds the input
// off. No clearing pass follows reset: a high-water mark tells slots never
// written apart, and the block is ready right out of reset.
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// Top level: sequencer plus node table datapath, valid/stall on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_doubly_linked_list #(
	parameter int CAPACITY    = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [idll_pkg::OP_W-1:0]     op,
	input  wire logic [idll_pkg::POS_W-1:0]    position,
	input  wire logic [idll_pkg::DATA_W-1:0]   value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [idll_pkg::STATUS_W-1:0] status,
	output logic      [idll_pkg::DATA_W-1:0]   read_value,
	output logic      [idll_pkg::LINK_W-1:0]   link,
	output logic      [idll_pkg::COUNT_W-1:0]  entry_count
);

	idll_pkg::cmd_t     cmd;
	idll_pkg::dp_stat_t stat;

	idll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	idll_dp #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (op),
		.position    (position),
		.value       (value),
		.status      (status),
		.read_value  (read_value),
		.link        (link),
		.entry_count (entry_count)
	);

endmodule

`default_nettype wire

@@ rtl/idll_ctrl.sv @@
// ----------------------------------------------------------------------------
// idll_ctrl
// Sequencer for one operation at a time: read, write passes, result
// handoff, and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire idll_pkg::dp_stat_t   stat,
	output idll_pkg::cmd_t            cmd
);

	idll_pkg::state_t state_q;
	idll_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic             out_free;
	logic             can_take;
	logic             accept;

	assign out_free = !out_valid_q || !out_stall;
	assign can_take = (state_q == idll_pkg::S_IDLE) ||
	                  ((state_q == idll_pkg::S_EMIT) && out_free);
	assign accept   = in_valid && can_take;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			idll_pkg::S_IDLE: begin
				if (accept) state_nxt = idll_pkg::S_EXEC;
			end
			idll_pkg::S_EXEC: begin
				state_nxt = stat.need_link ? idll_pkg::S_LINK : idll_pkg::S_EMIT;
			end
			idll_pkg::S_LINK: begin
				state_nxt = idll_pkg::S_EMIT;
			end
			idll_pkg::S_EMIT: begin
				// hold until the output register frees up
				if (out_free) state_nxt = accept ? idll_pkg::S_EXEC : idll_pkg::S_IDLE;
			end
			default: begin
				state_nxt = idll_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = !can_take;
		cmd.load = accept;
		cmd.exec = (state_q == idll_pkg::S_EXEC);
		cmd.link = (state_q == idll_pkg::S_LINK);
		cmd.emit = (state_q == idll_pkg::S_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= idll_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/idll_dp.sv @@
// ----------------------------------------------------------------------------
// idll_dp
// Node tables, sentinel links, free list head, counters and the output
// register. Slots at or above the high-water mark have never been written
// and read back as empty, unlinked slots chained to the next slot.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_dp #(
	parameter int CAPACITY    = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire idll_pkg::cmd_t                cmd,
	output idll_pkg::dp_stat_t                 stat,
	input  wire logic [idll_pkg::OP_W-1:0]     op,
	input  wire logic [idll_pkg::POS_W-1:0]    position,
	input  wire logic [idll_pkg::DATA_W-1:0]   value,
	output logic      [idll_pkg::STATUS_W-1:0] status,
	output logic      [idll_pkg::DATA_W-1:0]   read_value,
	output logic      [idll_pkg::LINK_W-1:0]   link,
	output logic      [idll_pkg::COUNT_W-1:0]  entry_count
);

	localparam int                IDX_W = $clog2(CAPACITY);
	localparam int                HW_W  = IDX_W + 1;
	localparam logic [IDX_W-1:0]  LAST  = IDX_W'(CAPACITY - 1);
	localparam logic [16:0]       CAP17 = 17'(CAPACITY);

	function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
		return (s == LAST) ? '0 : s + 1'b1;
	endfunction

	// node tables
	logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
	logic [IDX_W-1:0]       next_mem [CAPACITY];
	logic [IDX_W-1:0]       prev_mem [CAPACITY];
	logic                   used_mem [CAPACITY];

	// operation registers
	idll_pkg::op_t          op_q;
	logic [IDX_W-1:0]       pos_q;
	logic                   pos_ok_q;
	logic [VALUE_WIDTH-1:0] val_q;

	// registered read data
	logic [VALUE_WIDTH-1:0] val_rd_q;
	logic [IDX_W-1:0]       next_rd_q;
	logic [IDX_W-1:0]       prev_rd_q;
	logic                   used_rd_q;
	logic [IDX_W-1:0]       fnext_rd_q;

	// list state
	logic [IDX_W-1:0]       head_q;
	logic [IDX_W-1:0]       tail_q;
	logic [IDX_W-1:0]       free_head_q;
	logic [HW_W-1:0]        hw_q;
	logic [IDX_W-1:0]       count_q;

	// second write pass
	logic                   w2n_en_q;
	logic [IDX_W-1:0]       w2n_addr_q;
	logic [IDX_W-1:0]       w2n_data_q;
	logic                   w2p_en_q;
	logic [IDX_W-1:0]       w2p_addr_q;
	logic [IDX_W-1:0]       w2p_data_q;

	// result and output registers
	idll_pkg::status_t      res_status_q;
	logic [VALUE_WIDTH-1:0] res_rd_q;
	logic [IDX_W-1:0]       res_link_q;
	idll_pkg::status_t      status_q;
	logic [idll_pkg::DATA_W-1:0]  read_value_q;
	logic [idll_pkg::LINK_W-1:0]  link_q;
	logic [idll_pkg::COUNT_W-1:0] entry_count_q;

	logic [IDX_W-1:0]       in_idx;
	logic [63:0]            value_ext;
	logic [63:0]            rd_ext;

	logic                   pos_zero;
	logic                   pos_fresh;
	logic                   fh_fresh;
	logic [VALUE_WIDTH-1:0] val_p;
	logic [IDX_W-1:0]       next_p;
	logic [IDX_W-1:0]       prev_p;
	logic                   linked_p;
	logic [IDX_W-1:0]       fh_next;
	logic                   full;
	logic                   act_ins;
	logic                   act_del;

	idll_pkg::status_t      res_status;
	logic [VALUE_WIDTH-1:0] res_rd;
	logic [IDX_W-1:0]       res_link;

	logic                   vw_en;
	logic [IDX_W-1:0]       vw_addr;
	logic [VALUE_WIDTH-1:0] vw_data;
	logic                   nw_en;
	logic [IDX_W-1:0]       nw_addr;
	logic [IDX_W-1:0]       nw_data;
	logic                   pw_en;
	logic [IDX_W-1:0]       pw_addr;
	logic [IDX_W-1:0]       pw_data;
	logic                   uw_en;
	logic [IDX_W-1:0]       uw_addr;
	logic                   uw_data;

	assign in_idx    = IDX_W'(position);
	assign value_ext = 64'(value);

	// resolve reads against the sentinel registers and the high-water mark
	always_comb begin
		pos_zero  = (pos_q == '0);
		pos_fresh = !pos_zero && ({1'b0, pos_q} >= hw_q);
		fh_fresh  = ({1'b0, free_head_q} >= hw_q);
		if (pos_zero) begin
			val_p    = '0;
			next_p   = head_q;
			prev_p   = tail_q;
			linked_p = 1'b1;
		end else if (pos_fresh) begin
			val_p    = '0;
			next_p   = slot_inc(pos_q);
			prev_p   = '0;
			linked_p = 1'b0;
		end else begin
			val_p    = val_rd_q;
			next_p   = next_rd_q;
			prev_p   = prev_rd_q;
			linked_p = used_rd_q;
		end
		fh_next = fh_fresh ? slot_inc(free_head_q) : fnext_rd_q;
		full    = (count_q >= LAST);
		act_ins = (op_q == idll_pkg::OP_INSERT) && pos_ok_q && !full && linked_p;
		act_del = (op_q == idll_pkg::OP_DELETE) && pos_ok_q && !pos_zero && linked_p;
	end

	assign stat.need_link = act_ins || act_del;

	always_comb begin
		res_status = idll_pkg::ST_OK;
		res_rd     = '0;
		res_link   = '0;
		case (op_q)
			idll_pkg::OP_GET: begin
				if (pos_ok_q) res_rd = val_p;
			end
			idll_pkg::OP_NEXT: begin
				if (pos_ok_q) res_link = next_p;
			end
			idll_pkg::OP_PREV: begin
				if (pos_ok_q) res_link = prev_p;
			end
			idll_pkg::OP_INSERT: begin
				if (pos_ok_q && full) begin
					res_status = idll_pkg::ST_FULL;
				end else if (act_ins) begin
					res_link = free_head_q;
				end
			end
			idll_pkg::OP_DELETE: begin
				if (pos_ok_q && pos_zero) res_status = idll_pkg::ST_SENTINEL;
			end
			default: begin
				res_status = idll_pkg::ST_OK;
			end
		endcase
	end

	// table write port selection; first pass touches the moved slot (and, on
	// delete, the successor's prev link), second pass patches the other links
	always_comb begin
		vw_en   = 1'b0;
		vw_addr = free_head_q;
		vw_data = val_q;
		nw_en   = 1'b0;
		nw_addr = free_head_q;
		nw_data = next_p;
		pw_en   = 1'b0;
		pw_addr = free_head_q;
		pw_data = pos_q;
		uw_en   = 1'b0;
		uw_addr = free_head_q;
		uw_data = 1'b1;
		if (cmd.exec && act_ins) begin
			vw_en = 1'b1;
			nw_en = 1'b1;
			pw_en = 1'b1;
			uw_en = 1'b1;
		end else if (cmd.exec && act_del) begin
			vw_en   = 1'b1;
			vw_addr = pos_q;
			vw_data = '0;
			nw_en   = 1'b1;
			nw_addr = pos_q;
			nw_data = free_head_q;
			pw_en   = 1'b1;
			pw_addr = next_p;
			pw_data = prev_p;
			uw_en   = 1'b1;
			uw_addr = pos_q;
			uw_data = 1'b0;
		end else if (cmd.link) begin
			nw_en   = w2n_en_q;
			nw_addr = w2n_addr_q;
			nw_data = w2n_data_q;
			pw_en   = w2p_en_q;
			pw_addr = w2p_addr_q;
			pw_data = w2p_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (vw_en) val_mem[vw_addr] <= vw_data;
		if (nw_en && (nw_addr != '0)) next_mem[nw_addr] <= nw_data;
		if (pw_en && (pw_addr != '0)) prev_mem[pw_addr] <= pw_data;
		if (uw_en) used_mem[uw_addr] <= uw_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_rd_q   <= val_mem[in_idx];
			next_rd_q  <= next_mem[in_idx];
			prev_rd_q  <= prev_mem[in_idx];
			used_rd_q  <= used_mem[in_idx];
			fnext_rd_q <= next_mem[free_head_q];
			op_q       <= idll_pkg::op_t'(op);
			pos_q      <= in_idx;
			pos_ok_q   <= ({7'd0, position} < CAP17);
			val_q      <= value_ext[VALUE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= res_status;
			res_rd_q     <= res_rd;
			res_link_q   <= res_link;
			w2n_en_q     <= act_ins || act_del;
			w2n_addr_q   <= act_ins ? pos_q : prev_p;
			w2n_data_q   <= act_ins ? free_head_q : next_p;
			w2p_en_q     <= act_ins;
			w2p_addr_q   <= next_p;
			w2p_data_q   <= free_head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			free_head_q <= IDX_W'(1);
			hw_q        <= HW_W'(1);
			count_q     <= '0;
		end else begin
			if (nw_en && (nw_addr == '0)) head_q <= nw_data;
			if (pw_en && (pw_addr == '0)) tail_q <= pw_data;
			if (cmd.exec && act_ins) begin
				free_head_q <= fh_next;
				count_q     <= count_q + 1'b1;
				// advance the mark when the slot comes fresh from the table
				if ({1'b0, free_head_q} == hw_q) hw_q <= hw_q + 1'b1;
			end else if (cmd.exec && act_del) begin
				free_head_q <= pos_q;
				count_q     <= count_q - 1'b1;
			end
		end
	end

	assign rd_ext = 64'(res_rd_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q      <= res_status_q;
			read_value_q  <= rd_ext[idll_pkg::DATA_W-1:0];
			link_q        <= idll_pkg::LINK_W'(res_link_q);
			entry_count_q <= idll_pkg::COUNT_W'(count_q);
		end
	end

	assign status      = status_q;
	assign read_value  = read_value_q;
	assign link        = link_q;
	assign entry_count = entry_count_q;

endmodule

`default_nettype wire

@@ rtl/idll_check.sv @@
// ----------------------------------------------------------------------------
// idll_check
// Port-level checks for the linked list, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_doubly_linked_list_macros.svh"

module idll_check (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic [idll_pkg::OP_W-1:0]     op,
	input wire logic [idll_pkg::POS_W-1:0]    position,
	input wire logic [idll_pkg::DATA_W-1:0]   value,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [idll_pkg::STATUS_W-1:0] status,
	input wire logic [idll_pkg::DATA_W-1:0]   read_value,
	input wire logic [idll_pkg::LINK_W-1:0]   link,
	input wire logic [idll_pkg::COUNT_W-1:0]  entry_count
);

	// one operation at a time: busy right after an accepted beat
	`IDLL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// a stalled result beat holds
	`IDLL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(link) && $stable(status) && $stable(read_value) && $stable(entry_count))

	// a refused or full operation reports no data and no slot
	`IDLL_ASSERT_IMPL(a_err_no_data, out_valid && (status != idll_pkg::ST_OK), (read_value == '0) && (link == '0))

	// a value read never comes with a link or an error
	`IDLL_ASSERT_IMPL(a_read_alone, out_valid && (read_value != '0), (link == '0) && (status == idll_pkg::ST_OK))

endmodule

bind indexed_doubly_linked_list idll_check u_idll_check (.*);

`default_nettype wire
